// File: hw/rtl/cre_pkg.sv
// Shared types, constants and the elaboration-time log table builder for the
// companded record encoder. No dependencies; imported by the datapath and controller.

package cre_pkg;

    // Field widths.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned MAG_W    = 11;
    localparam int unsigned LOG_W    = 7;
    localparam int unsigned IDX_W    = 8;
    localparam int unsigned CODE_W   = 12;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned DIGIT_W  = 4;

    // Scaling and log-law constants.
    localparam int unsigned FULL_SCALE  = 2047;
    localparam int unsigned ROUND_HALF  = 16384;
    localparam int unsigned SCALE_SHIFT = 15;
    localparam int unsigned LOG_MU      = 100;
    localparam int unsigned LOG_BASE    = LOG_MU + 1;
    localparam int unsigned LOG_MAX     = 127;
    localparam int unsigned LOG_DEPTH   = 2048;
    localparam int unsigned LOG_FRAC    = 56;

    // Divide-by-ten by reciprocal, exact for counts below 1029.
    localparam int unsigned DIV10_MUL   = 205;
    localparam int unsigned DIV10_SHIFT = 11;

    // Characters.
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'd0;

    typedef logic [LOG_W-1:0] t_log_rom [LOG_DEPTH];

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_sample;
        logic look_up;
        logic write_code;
        logic load_count;
        logic load_item;
        logic load_newline;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flush;
        logic idx_last;
        logic out_free;
    } t_dp_stat;

    // Fixed-point product (a * b) >> 60 for a, b below 2^61.
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Base-2 logarithm with 56 fraction bits, by repeated squaring.
    function automatic logic [63:0] log2_q56(input logic [31:0] n);
        logic [63:0] m;
        logic [63:0] frac;
        int          e;
        int          k;
        e = 31;
        while (e > 0 && n[e] == 1'b0) begin
            e = e - 1;
        end
        m    = 64'(n) << (60 - e);
        frac = '0;
        for (k = 0; k < LOG_FRAC; k++) begin
            m    = mul_q60(m, m);
            frac = frac << 1;
            if (m >= (64'd1 << 61)) begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(e) << LOG_FRAC) | frac;
    endfunction

    // Builds the mu-law table: round(127 * ln(1 + 100 i / 2047) / ln(101)).
    // The rounded quotient is found by a bitwise search instead of a divide.
    function automatic t_log_rom build_log_rom();
        t_log_rom    rom;
        logic [63:0] base;
        logic [63:0] den;
        logic [63:0] l;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] trial;
        int          i;
        int          b;
        base = log2_q56(32'(FULL_SCALE));
        den  = log2_q56(32'(LOG_BASE)) >> 8;
        for (i = 0; i < LOG_DEPTH; i++) begin
            l   = log2_q56(32'(FULL_SCALE + LOG_MU * i));
            d   = (l > base) ? ((l - base) >> 8) : 64'd0;
            num = 64'(2 * LOG_MAX) * d + den;
            q   = '0;
            for (b = 7; b >= 0; b--) begin
                trial = q | (64'd1 << b);
                if (trial * (den << 1) <= num) begin
                    q = trial;
                end
            end
            rom[i] = (q > 64'(LOG_MAX)) ? LOG_W'(LOG_MAX) : q[LOG_W-1:0];
        end
        return rom;
    endfunction

endpackage

// File: hw/rtl/cre_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.

module cre_ram #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, read every cycle.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/cre_ctrl.sv
// Sequencing state machine of the companded record encoder.
// Depends on cre_pkg for the command and status structs.

module cre_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  cre_pkg::t_dp_stat i_stat,
    output cre_pkg::t_dp_cmd  o_cmd
);

    import cre_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_LOOK    = 7'b0000010,
        S_WRITE   = 7'b0000100,
        S_COUNT   = 7'b0001000,
        S_READ    = 7'b0010000,
        S_SEND    = 7'b0100000,
        S_NEWLINE = 7'b1000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd s_cmd;
    logic    s_ready;

    // Next-state and command decode.
    always_comb begin
        n_state = r_state;
        s_cmd   = '0;
        s_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_ready = 1'b1;
                if (i_s_valid) begin
                    s_cmd.load_sample = 1'b1;
                    n_state           = S_LOOK;
                end
            end
            S_LOOK: begin
                s_cmd.look_up = 1'b1;
                n_state       = S_WRITE;
            end
            S_WRITE: begin
                s_cmd.write_code = 1'b1;
                if (i_stat.flush) begin
                    n_state = S_COUNT;
                end else begin
                    // The next item can enter while this code is stored.
                    s_ready = 1'b1;
                    if (i_s_valid) begin
                        s_cmd.load_sample = 1'b1;
                        n_state           = S_LOOK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_COUNT: begin
                if (i_stat.out_free) begin
                    s_cmd.load_count = 1'b1;
                    n_state          = S_READ;
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_stat.out_free) begin
                    s_cmd.load_item = 1'b1;
                    n_state         = i_stat.idx_last ? S_NEWLINE : S_READ;
                end
            end
            S_NEWLINE: begin
                if (i_stat.out_free) begin
                    s_cmd.load_newline = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd     = s_cmd;
    assign o_s_ready = s_ready;

endmodule

// File: hw/rtl/cre_datapath.sv
// Datapath of the companded record encoder: scaling, log lookup, code buffer,
// counters and the output register. Depends on cre_pkg and cre_ram.

module cre_datapath #(
    parameter int unsigned RECORD_SAMPLES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_compressed_mode,
    input  logic [cre_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                          i_end_of_data,
    input  cre_pkg::t_dp_cmd              i_cmd,
    output cre_pkg::t_dp_stat             o_stat,
    output logic                          o_m_valid,
    input  logic                          i_m_ready,
    output logic [cre_pkg::CHAR_W-1:0]    o_first_char,
    output logic [cre_pkg::CHAR_W-1:0]    o_second_char,
    output logic                          o_second_valid,
    output logic                          o_record_end
);

    import cre_pkg::*;

    localparam int unsigned AW = (RECORD_SAMPLES > 1) ? $clog2(RECORD_SAMPLES) : 1;
    localparam int unsigned CW = $clog2(RECORD_SAMPLES + 1);
    localparam t_log_rom LOG_ROM = build_log_rom();

    // Scaling signals.
    logic                      s_neg;
    logic [SAMPLE_W:0]         s_mag;
    logic [27:0]               s_prod;
    logic [MAG_W-1:0]          s_scaled;

    // Code forming signals.
    logic [IDX_W-1:0]          s_log_idx;
    logic [CODE_W-1:0]         s_comp_code;
    logic [CODE_W-1:0]         s_lin_code;
    logic [CODE_W-1:0]         s_code;
    logic [CODE_W-1:0]         w_rd_code;

    // Count digits.
    logic [CNT_W-1:0]          s_cnt;
    logic [14:0]               s_tens_prod;
    logic [DIGIT_W-1:0]        s_tens;
    logic [DIGIT_W-1:0]        s_units;

    // Registers.
    logic                      r_neg;
    logic [MAG_W-1:0]          r_mag;
    logic                      r_eod;
    logic [LOG_W-1:0]          r_log;
    logic [CW-1:0]             r_fill;
    logic [AW-1:0]             r_idx;
    logic                      r_m_valid;
    logic [CHAR_W-1:0]         r_first;
    logic [CHAR_W-1:0]         r_second;
    logic                      r_sv;
    logic                      r_re;

    // Sample magnitude scaled by 2047/32768, halves rounded away from zero.
    assign s_neg    = i_sample[SAMPLE_W-1];
    assign s_mag    = s_neg ? (17'h10000 - {1'b0, i_sample}) : {1'b0, i_sample};
    assign s_prod   = 28'(s_mag) * 28'(FULL_SCALE) + 28'(ROUND_HALF);
    assign s_scaled = s_prod[SCALE_SHIFT +: MAG_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_neg <= s_neg;
            r_mag <= s_scaled;
            r_eod <= i_end_of_data;
        end
    end

    // Log table lookup with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.look_up) begin
            r_log <= LOG_ROM[r_mag];
        end
    end

    // Positive values take the complement of the table index within 256.
    assign s_log_idx   = r_neg ? {1'b0, r_log} : (IDX_W'(0) - {1'b0, r_log});
    assign s_comp_code = {s_log_idx, 4'd0};
    assign s_lin_code  = r_neg ? (CODE_W'(0) - {1'b0, r_mag}) : {1'b0, r_mag};
    assign s_code      = i_compressed_mode ? s_comp_code : s_lin_code;

    cre_ram #(
        .WIDTH (CODE_W),
        .DEPTH (RECORD_SAMPLES)
    ) u_code_buffer (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.write_code),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (s_code),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_code)
    );

    // Fill count and read index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.load_newline) begin
            r_fill <= '0;
        end else if (i_cmd.write_code) begin
            r_fill <= r_fill + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_count) begin
            r_idx <= '0;
        end else if (i_cmd.load_item) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // Decimal digits of the record count.
    assign s_cnt       = CNT_W'(r_fill);
    assign s_tens_prod = 15'(s_cnt) * 15'(DIV10_MUL);
    assign s_tens      = s_tens_prod[DIV10_SHIFT +: DIGIT_W];
    assign s_units     = DIGIT_W'(s_cnt - CNT_W'({s_tens, 3'd0}) - CNT_W'({s_tens, 1'd0}));

    // Output register; a new item loads when the slot is empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.load_count || i_cmd.load_item || i_cmd.load_newline) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_count) begin
            r_first  <= CHAR_ZERO + CHAR_W'(s_tens);
            r_second <= CHAR_ZERO + CHAR_W'(s_units);
            r_sv     <= 1'b1;
            r_re     <= 1'b0;
        end else if (i_cmd.load_item) begin
            r_first  <= CHAR_ZERO + CHAR_W'(w_rd_code[5:0]);
            r_second <= CHAR_ZERO + CHAR_W'(w_rd_code[CODE_W-1:6]);
            r_sv     <= 1'b1;
            r_re     <= 1'b0;
        end else if (i_cmd.load_newline) begin
            r_first  <= CHAR_NEWLINE;
            r_second <= CHAR_NONE;
            r_sv     <= 1'b0;
            r_re     <= 1'b1;
        end
    end

    // Status toward the controller.
    assign o_stat.flush    = r_eod || (r_fill == CW'(RECORD_SAMPLES - 1));
    assign o_stat.idx_last = (CW'(r_idx) + CW'(1)) == r_fill;
    assign o_stat.out_free = !r_m_valid || i_m_ready;

    assign o_m_valid      = r_m_valid;
    assign o_first_char   = r_first;
    assign o_second_char  = r_second;
    assign o_second_valid = r_sv;
    assign o_record_end   = r_re;

`ifndef SYNTHESIS
    // The buffer never holds more than one record.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(RECORD_SAMPLES))
        else $error("fill count beyond record length");

    // A code is only stored while there is room for it.
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_code |-> (r_fill < CW'(RECORD_SAMPLES)))
        else $error("code written into a full buffer");

    // Only buffered entries of the current record are read out.
    a_item_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_item |-> (CW'(r_idx) < r_fill))
        else $error("sample item read beyond fill count");

    // The newline item closes the record and empties the buffer.
    a_newline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_newline |=> ((r_fill == '0) && r_m_valid && r_re && !r_sv))
        else $error("record end did not clear the buffer");
`endif

endmodule

// File: hw/rtl/companded_record_encoder_unit.sv
// Companded record encoder: turns Q1.15 audio samples into records of
// character pairs, linear 12-bit or mu-law 8-bit codes.
// Input channel: s_axis_tdata = sample (16 bits), s_axis_tlast = end_of_data.
// Output channel: m_axis_tdata = first_char [7:0], second_char [15:8];
//   m_axis_tuser = second_valid; m_axis_tlast = record_end (newline item).
// Config: APB register 0 (byte address 0), bit 0 = compressed_mode; write
//   only while the block is idle. pready is always high.
// Sample flow: scale, table lookup and buffer write run as three steps on
//   one item; a new sample enters during the previous one's buffer write.
// After the last sample of a record (32 samples or tlast) input stalls while
//   the record goes out: the count item loads after that sample's store,
//   then each sample item after its registered buffer read, then the
//   newline item; input resumes once the newline item has loaded.
// A stalled receiver holds the output register; the sequence resumes when
//   m_axis_tready returns, and no item is dropped or repeated.
// Reset (synchronous, active low) empties the record, drops any pending
//   output item and selects linear mode; no clearing pass is needed.

module companded_record_encoder_unit #(
    parameter int unsigned RECORD_SAMPLES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] first_char, [15:8] second_char
    output logic        m_axis_tuser,   // [0] second_valid
    output logic        m_axis_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import cre_pkg::*;

    localparam logic REG_MODE = 1'b0;

    logic     r_mode;
    logic     s_reg_sel;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic [CHAR_W-1:0] w_first;
    logic [CHAR_W-1:0] w_second;

    // Register decode: the register index is the word address.
    assign s_reg_sel = (paddr[2] == REG_MODE);
    assign pready    = 1'b1;
    assign prdata    = s_reg_sel ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && s_reg_sel) begin
            r_mode <= pwdata[0];
        end
    end

    cre_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    cre_datapath #(
        .RECORD_SAMPLES (RECORD_SAMPLES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_compressed_mode (r_mode),
        .i_sample          (s_axis_tdata),
        .i_end_of_data     (s_axis_tlast),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_m_valid         (m_axis_tvalid),
        .i_m_ready         (m_axis_tready),
        .o_first_char      (w_first),
        .o_second_char     (w_second),
        .o_second_valid    (m_axis_tuser),
        .o_record_end      (m_axis_tlast)
    );

    assign m_axis_tdata = {w_second, w_first};

endmodule

// File: tb/sv/tb_companded_record_encoder_unit.sv
// Self-checking testbench for companded_record_encoder_unit: drives audio samples in
// linear and mu-law modes and checks every character item of the emitted records.
// Depends on cre_pkg and the RTL top level only.

module tb_companded_record_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cre_pkg::*;

    localparam int RECORD_LEN          = 32;
    localparam int REG_COMPRESSED_MODE = 0;
    localparam logic [2:0] ADDR_COMPRESSED_MODE = 3'(4 * REG_COMPRESSED_MODE);
    localparam int SETTLE_CYCLES       = 12;
    localparam int STALL_LIMIT         = 4000;
    localparam int SAMPLE_TARGET       = 460;

    // One character item of a record.
    typedef struct packed {
        logic [7:0] first_c;
        logic [7:0] second_c;
        logic       second_valid;
        logic       record_end;
    } t_char_item;

    // Predicts record contents and compares them with the emitted items.
    class t_record_scoreboard;
        logic [6:0]  mu_table [2048];
        bit          compressed;
        logic [11:0] record_codes [$];
        t_char_item  pending_items [$];
        int          mismatches;
        int          items_checked;
        int          samples_seen;
        int          records_seen;

        function new();
            logic [63:0] base_log;
            logic [63:0] den;
            logic [63:0] l;
            logic [63:0] d;
            logic [63:0] q;
            base_log = log2_fixed(2047);
            den      = log2_fixed(101) >> 8;
            for (int i = 0; i < 2048; i++) begin
                l = log2_fixed(2047 + 100 * i);
                d = (l > base_log) ? ((l - base_log) >> 8) : 64'd0;
                q = (64'd254 * d + den) / (64'd2 * den);
                mu_table[i] = (q > 64'd127) ? 7'd127 : q[6:0];
            end
        endfunction

        // Base-2 logarithm with 56 fraction bits, found by repeated squaring.
        function logic [63:0] log2_fixed(input int unsigned n);
            logic [63:0]  m;
            logic [63:0]  frac;
            logic [127:0] sq;
            int           e;
            e = 31;
            while (e > 0 && n[e] == 1'b0) e--;
            m    = 64'(n) << (60 - e);
            frac = '0;
            for (int k = 0; k < 56; k++) begin
                sq   = {64'd0, m} * {64'd0, m};
                m    = sq[123:60];
                frac = frac << 1;
                if (m >= (64'd1 << 61)) begin
                    m       = m >> 1;
                    frac[0] = 1'b1;
                end
            end
            return (64'(e) << 56) | frac;
        endfunction

        // round(2047 * x) with halves rounded away from zero.
        function int scale_sample(input logic [15:0] raw);
            int unsigned mag;
            int          r;
            mag = raw[15] ? (32'd65536 - raw) : raw;
            r   = int'((2047 * mag + 16384) >> 15);
            return raw[15] ? -r : r;
        endfunction

        function logic [11:0] sample_code(input int v);
            int unsigned idx;
            if (!compressed) return 12'(v);
            if (v > 2047) v = 2047;
            if (v < -2047) v = -2047;
            if (v <= 0) begin
                idx = mu_table[-v];
            end else begin
                idx = 256 - mu_table[v];
                if (idx == 256) idx = 0;
            end
            return 12'(idx * 16);
        endfunction

        function void report(input string msg);
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH: %s", msg);
        endfunction

        // Buffers the sample's code and queues the whole record once it flushes.
        function void note_sample(input logic [15:0] raw, input logic end_of_data);
            int         n;
            t_char_item it;
            samples_seen++;
            record_codes.push_back(sample_code(scale_sample(raw)));
            if (!end_of_data && record_codes.size() < RECORD_LEN) return;
            n  = record_codes.size();
            it = '{CHAR_ZERO + 8'((n / 10) % 10), CHAR_ZERO + 8'(n % 10), 1'b1, 1'b0};
            pending_items.push_back(it);
            foreach (record_codes[j]) begin
                it = '{CHAR_ZERO + 8'(record_codes[j][5:0]),
                       CHAR_ZERO + 8'(record_codes[j][11:6]), 1'b1, 1'b0};
                pending_items.push_back(it);
            end
            pending_items.push_back('{CHAR_NEWLINE, CHAR_NONE, 1'b0, 1'b1});
            record_codes.delete();
            records_seen++;
        endfunction

        function void check_item(input logic [15:0] tdata, input logic tuser, input logic tlast);
            t_char_item want;
            items_checked++;
            if (pending_items.size() == 0) begin
                report($sformatf("unexpected item tdata=%h tuser=%b tlast=%b",
                                 tdata, tuser, tlast));
                return;
            end
            want = pending_items.pop_front();
            if (tdata[7:0] !== want.first_c)
                report($sformatf("first_char exp %h got %h", want.first_c, tdata[7:0]));
            if (tdata[15:8] !== want.second_c)
                report($sformatf("second_char exp %h got %h", want.second_c, tdata[15:8]));
            if (tuser !== want.second_valid)
                report($sformatf("second_valid exp %b got %b", want.second_valid, tuser));
            if (tlast !== want.record_end)
                report($sformatf("record_end exp %b got %b", want.record_end, tlast));
        endfunction

        function int pending();
            return pending_items.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_record_scoreboard sb;
    bit                 steady;
    int                 stall_cycles;
    int                 mode_writes;

    companded_record_encoder_unit #(
        .RECORD_SAMPLES(RECORD_LEN)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock.
    always #5 i_clk = ~i_clk;

    // Receiver backpressure, held off during the steady stretch.
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 25);
    end

    // Output monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_item(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item accepted for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Sends one sample, with random idle cycles ahead of it outside the steady stretch.
    task automatic send_sample(input logic [15:0] raw, input logic end_of_data);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tlast  <= end_of_data;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(raw, end_of_data);
    endtask

    // Stops sending and waits until every queued record item has come out.
    task automatic drain_records();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the mode register over APB and reads it back.
    task automatic set_mode(input bit compressed);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_COMPRESSED_MODE;
        pwdata  <= {31'd0, compressed};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.compressed = compressed;
        mode_writes++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[0] !== compressed)
            sb.report($sformatf("mode readback exp %b got %b", compressed, prdata[0]));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly full-range values, with extremes and values near zero mixed in.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(40));
            3:       return -16'($urandom_range(40));
            default: return 16'($urandom);
        endcase
    endfunction

    // One record of random content; the shape decides how it is flushed.
    task automatic send_record();
        int len;
        case ($urandom_range(9))
            0, 1: begin
                // Fills the buffer completely, flushed by count alone.
                repeat (RECORD_LEN) send_sample(pick_sample(), 1'b0);
            end
            2: begin
                // Runs past a full buffer, then ends the short remainder.
                len = $urandom_range(RECORD_LEN + 1, RECORD_LEN + 12);
                for (int k = 1; k <= len; k++) send_sample(pick_sample(), k == len);
            end
            3: begin
                // Noise: end markers scattered at random.
                len = $urandom_range(2, 20);
                for (int k = 1; k <= len; k++)
                    send_sample(pick_sample(), (k == len) || ($urandom_range(99) < 20));
            end
            default: begin
                len = $urandom_range(1, RECORD_LEN);
                for (int k = 1; k <= len; k++) send_sample(pick_sample(), k == len);
            end
        endcase
    endtask

    initial begin
        int  phase;
        bit  mode;
        sb            = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        steady        = 1'b0;
        stall_cycles  = 0;
        mode_writes   = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Linear mode: full scale both ways, zero, exact halves, a single-sample record.
        set_mode(1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'd16384, 1'b0);
        send_sample(-16'd16384, 1'b0);
        send_sample(16'hffff, 1'b1);
        send_sample(16'd1, 1'b1);
        drain_records();

        // Compressed mode: the same extremes plus tiny values on both sides of zero.
        set_mode(1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'd16, 1'b0);
        send_sample(-16'd16, 1'b0);
        send_sample(16'd16384, 1'b0);
        send_sample(-16'd16384, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'haaaa, 1'b1);
        drain_records();

        // Random phases, each with its own mode, ending idle before the next write.
        phase = 0;
        mode  = 1'b1;
        while (sb.samples_seen < SAMPLE_TARGET) begin
            mode   = (phase < 2) ? ~mode : 1'($urandom);
            steady = (phase == 3);
            set_mode(mode);
            repeat ($urandom_range(1, 4)) send_record();
            drain_records();
            phase++;
        end
        steady = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d samples in %0d records over %0d mode settings,",
                 sb.samples_seen, sb.records_seen, mode_writes);
        $display("%0d items checked, %0d mismatches, %0d items still expected",
                 sb.items_checked, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
